// ===== src/ifsd_pkg.sv =====
// shared types and constants for the image frame stream deframer
package ifsd_pkg;

    localparam int unsigned MAX_PAYLOAD_BYTES = 1048576;
    localparam int unsigned HDR_LEN           = 32;
    localparam int unsigned HDR_IDX_W         = $clog2(HDR_LEN);

    localparam logic [31:0] HDR_MAGIC    = 32'h484E_4D46;
    localparam logic [15:0] HDR_VERSION  = 16'd1;
    localparam logic [15:0] HDR_SIZE     = 16'(HDR_LEN);
    localparam logic [7:0]  HDR_ENCODING = 8'd1;

    localparam logic [15:0] RST_MAX_WIDTH   = 16'd1920;
    localparam logic [15:0] RST_MAX_HEIGHT  = 16'd1080;
    localparam logic [20:0] RST_MAX_PAYLOAD = 21'd1048576;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 8'd2;

    localparam logic ERR_IDENTITY = 1'b0;
    localparam logic ERR_LIMITS   = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALT    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [15:0] max_width;
        logic [15:0] max_height;
        logic [20:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        last;
        logic        error_code;
        logic [31:0] sequence_res;
        logic [63:0] timestamp_ms;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [20:0] payload_length;
    } res_t;

endpackage

// ===== src/ifsd_cfg_regs.sv =====
// configuration registers for frame limits
module ifsd_cfg_regs
    import ifsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_WIDTH:   cfg_next.max_width   = cfg_data[15:0];
                CFG_MAX_HEIGHT:  cfg_next.max_height  = cfg_data[15:0];
                CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data[20:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_width   <= RST_MAX_WIDTH;
            cfg_reg.max_height  <= RST_MAX_HEIGHT;
            cfg_reg.max_payload <= RST_MAX_PAYLOAD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/ifsd_in_stage.sv =====
// input register stage
module ifsd_in_stage
    import ifsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  [7:0] data_byte,
    input  logic  restart,
    input  logic  advance,
    output logic  fire,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign fire       = valid_reg && advance;
    assign item       = item_reg;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.data_byte <= data_byte;
            item_reg.restart   <= restart;
        end
    end

endmodule

// ===== src/ifsd_parser.sv =====
// frame parser: header capture, checks and payload count
module ifsd_parser
    import ifsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  item_t item,
    input  cfg_t  cfg,
    output logic  res_valid,
    output res_t  res
);

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [HDR_IDX_W-1:0] count_reg;
    logic [HDR_IDX_W-1:0] count_next;
    logic [20:0]          left_reg;
    logic [20:0]          left_next;
    logic [20:0]          left_dec;
    logic [7:0]           hdr_reg [0:HDR_LEN-1];

    logic                 hdr_done;
    logic [8*HDR_LEN-1:0] hdr;
    logic [31:0]          magic;
    logic [15:0]          version;
    logic [15:0]          hsize;
    logic [7:0]           enc;
    logic [7:0]           flags;
    logic [15:0]          resv;
    logic [15:0]          width;
    logic [15:0]          height;
    logic [31:0]          len;
    logic [31:0]          lim;
    logic                 id_bad;
    logic                 lim_bad;

    // flat big-endian header, last byte taken straight from the input
    always_comb
    begin
        for (int k = 0; k < HDR_LEN; k++)
        begin
            hdr[8*(HDR_LEN-1-k) +: 8] = (k == HDR_LEN - 1) ? item.data_byte : hdr_reg[k];
        end
    end

    assign magic   = hdr[255:224];
    assign version = hdr[223:208];
    assign hsize   = hdr[207:192];
    assign width   = hdr[95:80];
    assign height  = hdr[79:64];
    assign enc     = hdr[63:56];
    assign flags   = hdr[55:48];
    assign len     = hdr[47:16];
    assign resv    = hdr[15:0];

    assign lim = ({11'd0, cfg.max_payload} > 32'(MAX_PAYLOAD_BYTES)) ?
                 32'(MAX_PAYLOAD_BYTES) : {11'd0, cfg.max_payload};

    assign id_bad  = (magic != HDR_MAGIC) || (version != HDR_VERSION) ||
                     (hsize != HDR_SIZE) || (enc != HDR_ENCODING) ||
                     (flags != 8'd0) || (resv != 16'd0);
    assign lim_bad = (width == 16'd0) || (height == 16'd0) ||
                     (width > cfg.max_width) || (height > cfg.max_height) ||
                     (len == 32'd0) || (len > lim);

    assign hdr_done = (count_reg == HDR_IDX_W'(HDR_LEN - 1));
    assign left_dec = (left_reg != 21'd0) ? left_reg - 21'd1 : left_reg;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        left_next  = left_reg;
        if (fire)
        begin
            if (item.restart)
            begin
                phase_next = PH_HEADER;
                count_next = '0;
                left_next  = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        count_next = count_reg + 1'b1;
                        if (hdr_done)
                        begin
                            if (id_bad || lim_bad)
                            begin
                                phase_next = PH_HALT;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                                left_next  = len[20:0];
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        left_next = left_dec;
                        if (left_dec == 21'd0)
                        begin
                            phase_next = PH_HEADER;
                            count_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // result
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (fire && !item.restart)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_done)
                    begin
                        res_valid = 1'b1;
                        if (id_bad)
                        begin
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_IDENTITY;
                        end
                        else if (lim_bad)
                        begin
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_LIMITS;
                        end
                        else
                        begin
                            res.kind           = KIND_HEADER;
                            res.sequence_res   = hdr[191:160];
                            res.timestamp_ms   = hdr[159:96];
                            res.frame_width    = width;
                            res.frame_height   = height;
                            res.payload_length = len[20:0];
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = item.data_byte;
                    res.last         = (left_dec == 21'd0);
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && !item.restart && (phase_reg == PH_HEADER))
        begin
            hdr_reg[count_reg] <= item.data_byte;
        end
    end

endmodule

// ===== src/ifsd_out_stage.sv =====
// result register stage
module ifsd_out_stage
    import ifsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  res_t res,
    output logic advance,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_res
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? res_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== src/image_frame_stream_deframer_core.sv =====
// top level of the image frame stream deframer
//
//  channel  | handshake              | content
//  ---------+------------------------+----------------------------------------------
//  input    | in_valid / in_stall    | data_byte, restart
//  output   | out_valid / out_stall  | kind, payload_byte, last, error_code, header
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  one transaction per cycle sustained while out_stall is low; path is input register
//  then result register, with the whole header check in between
//  reset clears parse state and loads the limit registers with their defaults
//  a stalled output holds its result while one more input transaction is taken
//  cfg_ready is always high
module image_frame_stream_deframer_core
    import ifsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [7:0]           payload_byte,
    output logic                 last,
    output logic                 error_code,
    output logic [31:0]          sequence_res,
    output logic [63:0]          timestamp_ms,
    output logic [15:0]          frame_width,
    output logic [15:0]          frame_height,
    output logic [20:0]          payload_length,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t  cfg;
    item_t item;
    logic  fire;
    logic  advance;
    logic  res_valid;
    res_t  res;
    res_t  out_res;

    ifsd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ifsd_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .restart   (restart),
        .advance   (advance),
        .fire      (fire),
        .item      (item)
    );

    ifsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    ifsd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind           = out_res.kind;
    assign payload_byte   = out_res.payload_byte;
    assign last           = out_res.last;
    assign error_code     = out_res.error_code;
    assign sequence_res   = out_res.sequence_res;
    assign timestamp_ms   = out_res.timestamp_ms;
    assign frame_width    = out_res.frame_width;
    assign frame_height   = out_res.frame_height;
    assign payload_length = out_res.payload_length;

endmodule

// ===== src/ifsd_checker.sv =====
// port-level checks for the deframer, bound to the top level
module ifsd_checker
    import ifsd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  payload_byte,
    input logic        last,
    input logic [31:0] sequence_res,
    input logic [63:0] timestamp_ms,
    input logic [15:0] frame_width
);

    // a stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_HEADER || kind == KIND_PAYLOAD || kind == KIND_ERROR)
        else $error("bad result kind");

    // only payload transactions carry data and last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0 && !last)
        else $error("payload fields set outside payload");

    // only accepted headers carry decoded fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_HEADER |->
            sequence_res == 32'd0 && timestamp_ms == 64'd0 && frame_width == 16'd0)
        else $error("header fields set outside header");

endmodule

bind image_frame_stream_deframer_core ifsd_checker u_ifsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last),
    .sequence_res (sequence_res),
    .timestamp_ms (timestamp_ms),
    .frame_width  (frame_width)
);

// ===== sim/tb_image_frame_stream_deframer_core.sv =====
// self-checking testbench for the image frame stream deframer core
module tb_image_frame_stream_deframer_core;
    import ifsd_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int PIPE_DEPTH     = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 400;
    localparam int HOLD_CYCLES    = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd3;

    typedef enum int {
        DEF_MAGIC,
        DEF_VERSION,
        DEF_HSIZE,
        DEF_ENCODING,
        DEF_FLAGS,
        DEF_RESERVED,
        DEF_ZERO_WIDTH,
        DEF_ZERO_HEIGHT,
        DEF_WIDE,
        DEF_TALL,
        DEF_ZERO_LEN,
        DEF_LONG_LEN
    } defect_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] hsize;
        logic [31:0] seq;
        logic [63:0] ts;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  enc;
        logic [7:0]  flags;
        logic [31:0] len;
        logic [15:0] resv;
    } frame_hdr_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           data_byte;
    logic                 restart;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           kind;
    logic [7:0]           payload_byte;
    logic                 last;
    logic                 error_code;
    logic [31:0]          sequence_res;
    logic [63:0]          timestamp_ms;
    logic [15:0]          frame_width;
    logic [15:0]          frame_height;
    logic [20:0]          payload_length;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    phase_t      dec_phase   = PH_HEADER;
    logic [5:0]  dec_hdr_cnt = '0;
    logic [7:0]  dec_hdr [32];
    logic [20:0] dec_left    = '0;
    logic [15:0] lim_w       = RST_MAX_WIDTH;
    logic [15:0] lim_h       = RST_MAX_HEIGHT;
    logic [20:0] lim_pay     = RST_MAX_PAYLOAD;

    res_t expected_results [$];
    int   fails       = 0;
    int   idle_cycles = 0;
    int   hold_req    = 0;
    bit   tx_gaps     = 1'b0;
    bit   rx_gaps     = 1'b0;

    image_frame_stream_deframer_core uut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [31:0] pay_cap();
        return (lim_pay > MAX_PAYLOAD_BYTES) ? 32'(MAX_PAYLOAD_BYTES) : 32'(lim_pay);
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic rs);
        res_t        r;
        logic [31:0] magic;
        logic [31:0] len;
        logic [15:0] version;
        logic [15:0] hsize;
        logic [15:0] resv;
        logic [15:0] fw;
        logic [15:0] fh;
        r = '0;
        if (rs)
        begin
            dec_phase   = PH_HEADER;
            dec_hdr_cnt = '0;
            dec_left    = '0;
            return;
        end
        if (dec_phase == PH_HALT)
            return;
        if (dec_phase == PH_PAYLOAD)
        begin
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            if (dec_left != 0)
                dec_left = dec_left - 1'b1;
            if (dec_left == 0)
            begin
                r.last      = 1'b1;
                dec_phase   = PH_HEADER;
                dec_hdr_cnt = '0;
            end
            expected_results.push_back(r);
            return;
        end
        dec_hdr[dec_hdr_cnt[4:0]] = b;
        dec_hdr_cnt = dec_hdr_cnt + 1'b1;
        if (dec_hdr_cnt < HDR_LEN)
            return;
        dec_hdr_cnt = '0;
        magic   = {dec_hdr[0], dec_hdr[1], dec_hdr[2], dec_hdr[3]};
        version = {dec_hdr[4], dec_hdr[5]};
        hsize   = {dec_hdr[6], dec_hdr[7]};
        fw      = {dec_hdr[20], dec_hdr[21]};
        fh      = {dec_hdr[22], dec_hdr[23]};
        len     = {dec_hdr[26], dec_hdr[27], dec_hdr[28], dec_hdr[29]};
        resv    = {dec_hdr[30], dec_hdr[31]};
        if (magic != HDR_MAGIC || version != HDR_VERSION || hsize != HDR_SIZE ||
            dec_hdr[24] != HDR_ENCODING || dec_hdr[25] != 8'd0 || resv != 16'd0)
        begin
            r.kind       = KIND_ERROR;
            r.error_code = ERR_IDENTITY;
            dec_phase    = PH_HALT;
        end
        else if (fw == 0 || fh == 0 || fw > lim_w || fh > lim_h ||
                 len == 0 || len > pay_cap())
        begin
            r.kind       = KIND_ERROR;
            r.error_code = ERR_LIMITS;
            dec_phase    = PH_HALT;
        end
        else
        begin
            r.kind           = KIND_HEADER;
            r.sequence_res   = {dec_hdr[8], dec_hdr[9], dec_hdr[10], dec_hdr[11]};
            r.timestamp_ms   = {dec_hdr[12], dec_hdr[13], dec_hdr[14], dec_hdr[15],
                                dec_hdr[16], dec_hdr[17], dec_hdr[18], dec_hdr[19]};
            r.frame_width    = fw;
            r.frame_height   = fh;
            r.payload_length = len[20:0];
            dec_left         = len[20:0];
            dec_phase        = PH_PAYLOAD;
        end
        expected_results.push_back(r);
    endfunction

    function automatic frame_hdr_t good_header(input int unsigned max_len);
        frame_hdr_t  hd;
        logic [31:0] cap;
        cap = pay_cap();
        if (cap > max_len)
            cap = max_len;
        hd         = '0;
        hd.magic   = HDR_MAGIC;
        hd.version = HDR_VERSION;
        hd.hsize   = HDR_SIZE;
        hd.enc     = HDR_ENCODING;
        hd.seq     = $urandom;
        hd.ts      = {$urandom, $urandom};
        hd.w       = ($urandom_range(0, 7) == 0) ? lim_w : 16'($urandom_range(1, lim_w));
        hd.h       = ($urandom_range(0, 7) == 0) ? lim_h : 16'($urandom_range(1, lim_h));
        hd.len     = $urandom_range(1, cap);
        return hd;
    endfunction

    function automatic frame_hdr_t spoil_header(input frame_hdr_t hd, input defect_t d);
        case (d)
            DEF_MAGIC:       hd.magic   ^= 32'd1 << $urandom_range(0, 31);
            DEF_VERSION:     hd.version ^= 16'd1 << $urandom_range(0, 15);
            DEF_HSIZE:       hd.hsize   ^= 16'd1 << $urandom_range(0, 15);
            DEF_ENCODING:    hd.enc     ^= 8'd1 << $urandom_range(0, 7);
            DEF_FLAGS:       hd.flags   = 8'($urandom_range(1, 255));
            DEF_RESERVED:    hd.resv    = 16'($urandom_range(1, 65535));
            DEF_ZERO_WIDTH:  hd.w       = '0;
            DEF_ZERO_HEIGHT: hd.h       = '0;
            DEF_WIDE:        hd.w = (lim_w == 16'hFFFF) ? 16'd0 :
                                    16'($urandom_range(int'(lim_w) + 1, 65535));
            DEF_TALL:        hd.h = (lim_h == 16'hFFFF) ? 16'd0 :
                                    16'($urandom_range(int'(lim_h) + 1, 65535));
            DEF_ZERO_LEN:    hd.len     = '0;
            default:         hd.len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
                                      pay_cap() + $urandom_range(1, 64);
        endcase
        return hd;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic rs);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        restart   <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, rs);
    endtask

    task automatic send_restart();
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic send_payload(input int n);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom), 1'b0);
    endtask

    task automatic send_header(input frame_hdr_t hd, input int n);
        logic [255:0] bits;
        bits = hd;
        for (int i = 0; i < n; i++)
            send_item(bits[255 - 8 * i -: 8], 1'b0);
    endtask

    task automatic send_frame(input frame_hdr_t hd, input int n_pay);
        send_header(hd, HDR_LEN);
        send_payload(n_pay);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_MAX_WIDTH:   lim_w   = val[15:0];
            CFG_MAX_HEIGHT:  lim_h   = val[15:0];
            CFG_MAX_PAYLOAD: lim_pay = val[20:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_limits();
        frame_hdr_t hd;
        hd     = good_header(1);
        hd.w   = 16'd1;
        hd.h   = 16'd1;
        hd.seq = '0;
        hd.ts  = '0;
        send_frame(hd, 1);
        hd     = good_header(5);
        hd.w   = RST_MAX_WIDTH;
        hd.h   = RST_MAX_HEIGHT;
        hd.seq = '1;
        hd.ts  = '1;
        hd.len = 32'd5;
        send_frame(hd, 5);
        hd     = good_header(1);
        hd.len = MAX_PAYLOAD_BYTES;
        send_frame(hd, 4);
        send_restart();
        hd   = good_header(4);
        hd.w = RST_MAX_WIDTH + 1'b1;
        send_frame(hd, 3);
        send_restart();
        hd   = good_header(4);
        hd.h = RST_MAX_HEIGHT + 1'b1;
        send_frame(hd, 3);
        send_restart();
    endtask

    task automatic test_identity_errors();
        frame_hdr_t hd;
        for (int d = DEF_MAGIC; d <= DEF_RESERVED; d++)
        begin
            hd = spoil_header(good_header(4), defect_t'(d));
            send_frame(hd, 2);
            send_restart();
        end
        // identity and limits both broken
        hd   = spoil_header(good_header(4), DEF_MAGIC);
        hd.w = '0;
        send_frame(hd, 1);
        send_restart();
    endtask

    task automatic test_limit_errors();
        frame_hdr_t hd;
        for (int d = DEF_ZERO_WIDTH; d <= DEF_LONG_LEN; d++)
        begin
            hd = spoil_header(good_header(4), defect_t'(d));
            send_frame(hd, 2);
            send_restart();
        end
        hd     = good_header(4);
        hd.len = 32'hFFFF_FFFF;
        send_frame(hd, 1);
        send_restart();
    endtask

    task automatic test_restarts();
        frame_hdr_t hd;
        hd = good_header(8);
        send_header(hd, 10);
        send_restart();
        send_frame(hd, hd.len);
        hd     = good_header(8);
        hd.len = 32'd6;
        send_header(hd, HDR_LEN);
        send_payload(3);
        send_restart();
        send_restart();
        hd = good_header(8);
        send_frame(hd, hd.len);
    endtask

    task automatic test_register_extremes();
        frame_hdr_t hd;
        wait_idle();
        write_reg(CFG_MAX_WIDTH, 32'h0000_FFFF);
        write_reg(CFG_MAX_HEIGHT, 32'h0000_FFFF);
        write_reg(CFG_MAX_PAYLOAD, 32'h001F_FFFF);
        hd   = good_header(4);
        hd.w = '1;
        hd.h = '1;
        send_frame(hd, hd.len);
        hd     = good_header(1);
        hd.len = MAX_PAYLOAD_BYTES;
        send_frame(hd, 2);
        send_restart();
        hd.len = MAX_PAYLOAD_BYTES + 1;
        send_frame(hd, 2);
        send_restart();

        hd     = good_header(1);
        hd.w   = 16'd1;
        hd.h   = 16'd1;
        hd.len = 32'd1;
        wait_idle();
        write_reg(CFG_MAX_WIDTH, 32'd0);
        send_frame(hd, 1);
        send_restart();
        wait_idle();
        write_reg(CFG_MAX_WIDTH, 32'hFFFF_0001);
        write_reg(CFG_MAX_HEIGHT, 32'd0);
        send_frame(hd, 1);
        send_restart();
        wait_idle();
        write_reg(CFG_MAX_HEIGHT, 32'd1);
        write_reg(CFG_MAX_PAYLOAD, 32'd0);
        send_frame(hd, 1);
        send_restart();
        wait_idle();
        write_reg(CFG_MAX_PAYLOAD, 32'hFFE0_0001);
        send_frame(hd, 1);
        hd.w = 16'd2;
        send_frame(hd, 1);
        send_restart();
        hd.w   = 16'd1;
        hd.len = 32'd2;
        send_frame(hd, 1);
        send_restart();

        wait_idle();
        write_reg(CFG_UNUSED, 32'd0);
        hd.len = 32'd1;
        send_frame(hd, 1);
        wait_idle();
        write_reg(CFG_MAX_WIDTH, 32'(RST_MAX_WIDTH));
        write_reg(CFG_MAX_HEIGHT, 32'(RST_MAX_HEIGHT));
        write_reg(CFG_MAX_PAYLOAD, 32'(RST_MAX_PAYLOAD));
    endtask

    task automatic test_backpressure();
        frame_hdr_t hd;
        wait_idle();
        tx_gaps  = 1'b0;
        rx_gaps  = 1'b0;
        hd       = good_header(48);
        hd.len   = 32'd48;
        hold_req = HOLD_CYCLES;
        send_frame(hd, 48);
        wait_idle();
    endtask

    task automatic test_random_stream();
        frame_hdr_t hd;
        int         sent = 0;
        int         frames = 0;
        int         pick;
        int         n;
        while (sent < RANDOM_BYTES)
        begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            if (frames % 8 == 7)
            begin
                wait_idle();
                write_reg(CFG_MAX_WIDTH,
                          ($urandom_range(0, 3) == 0) ? 32'hFFFF : $urandom_range(1, 65535));
                write_reg(CFG_MAX_HEIGHT,
                          ($urandom_range(0, 3) == 0) ? 32'hFFFF : $urandom_range(1, 65535));
                case ($urandom_range(0, 3))
                    0:       write_reg(CFG_MAX_PAYLOAD, 32'h001F_FFFF);
                    1:       write_reg(CFG_MAX_PAYLOAD, $urandom_range(1, 16));
                    2:       write_reg(CFG_MAX_PAYLOAD, MAX_PAYLOAD_BYTES);
                    default: write_reg(CFG_MAX_PAYLOAD, $urandom_range(1, 32'h001F_FFFF));
                endcase
            end
            hd   = good_header(16);
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                send_frame(hd, hd.len);
                sent += HDR_LEN + hd.len;
            end
            else if (pick < 17)
            begin
                send_frame(spoil_header(hd, defect_t'($urandom_range(DEF_MAGIC, DEF_LONG_LEN))),
                           $urandom_range(0, 4));
                send_restart();
                sent += HDR_LEN;
            end
            else if (pick < 19)
            begin
                send_header(hd, $urandom_range(1, HDR_LEN - 1));
                send_restart();
            end
            else
            begin
                n = $urandom_range(0, hd.len - 1);
                send_frame(hd, n);
                send_restart();
                sent += HDR_LEN + n;
            end
            frames++;
        end
    endtask

    initial
    begin : rx_side
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                n        = hold_req;
                hold_req = 0;
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (idle_len()) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected: kind %0d", kind);
                fails++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, kind);
                check_field("payload_byte", want.payload_byte, payload_byte);
                check_field("last", want.last, last);
                check_field("error_code", want.error_code, error_code);
                check_field("sequence_res", want.sequence_res, sequence_res);
                check_field("timestamp_ms", want.timestamp_ms, timestamp_ms);
                check_field("frame_width", want.frame_width, frame_width);
                check_field("frame_height", want.frame_height, frame_height);
                check_field("payload_length", want.payload_length, payload_length);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = '0;
        restart   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        test_default_limits();
        test_identity_errors();
        test_limit_errors();
        test_restarts();
        test_register_extremes();
        test_backpressure();
        test_random_stream();
        wait_idle();
        repeat (PIPE_DEPTH * 2) @(posedge clk);
        if (fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
